// File: sv/jsu_pkg.sv
// Shared types, character codes and helper functions for the JSON string
// unescape unit. No dependencies; used by every module of the unit.
package jsu_pkg;

  // Decoder modes
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_STR    = 4'd1,
    MODE_ESC    = 4'd2,
    MODE_HEXHI  = 4'd3,
    MODE_PAIRBS = 4'd4,
    MODE_PAIRU  = 4'd5,
    MODE_HEXLO  = 4'd6
  } mode_t;

  // Kind of a result group
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Error codes
  localparam logic [3:0] ERR_EXPECT_QUOTE  = 4'd0;
  localparam logic [3:0] ERR_CONTROL_CHAR  = 4'd1;
  localparam logic [3:0] ERR_TRUNC_ESCAPE  = 4'd2;
  localparam logic [3:0] ERR_BAD_ESCAPE    = 4'd3;
  localparam logic [3:0] ERR_TRUNC_UNICODE = 4'd4;
  localparam logic [3:0] ERR_BAD_HEX       = 4'd5;
  localparam logic [3:0] ERR_MISSING_LOW   = 4'd6;
  localparam logic [3:0] ERR_BAD_LOW       = 4'd7;
  localparam logic [3:0] ERR_STRAY_LOW     = 4'd8;
  localparam logic [3:0] ERR_UNTERMINATED  = 4'd9;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Surrogate prefixes (top six bits of a 16-bit code unit)
  localparam logic [5:0] SURR_HIGH = 6'b110110;
  localparam logic [5:0] SURR_LOW  = 6'b110111;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // Decoder state
  typedef struct packed {
    mode_t       mode;
    logic [1:0]  hex_cnt;
    logic [15:0] acc;
    logic [9:0]  hi_bits;
  } dec_state_t;

  localparam dec_state_t IDLE_STATE = '{
    mode: MODE_IDLE, hex_cnt: 2'd0, acc: 16'd0, hi_bits: 10'd0
  };

  // Results caused by one input byte: one to four bytes, a done or an error
  typedef struct packed {
    logic            has_result;
    kind_t           kind;
    logic [3:0]      err;
    logic [1:0]      last;
    logic [3:0][7:0] bytes;
  } grp_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  function automatic grp_t byte_group(logic [7:0] b);
    grp_t g;
    g = '0;
    g.has_result = 1'b1;
    g.kind       = KIND_BYTE;
    g.bytes[0]   = b;
    return g;
  endfunction

  function automatic grp_t error_group(logic [3:0] code);
    grp_t g;
    g = '0;
    g.has_result = 1'b1;
    g.kind       = KIND_ERROR;
    g.err        = code;
    return g;
  endfunction

  function automatic grp_t done_group();
    grp_t g;
    g = '0;
    g.has_result = 1'b1;
    g.kind       = KIND_DONE;
    return g;
  endfunction

  // Encode a code point of up to 21 bits as one to four UTF-8 bytes
  function automatic grp_t utf8_group(logic [20:0] cp);
    grp_t g;
    g = '0;
    g.has_result = 1'b1;
    g.kind       = KIND_BYTE;
    if (cp <= 21'h7f) begin
      g.bytes[0] = cp[7:0];
      g.last     = 2'd0;
    end else if (cp <= 21'h7ff) begin
      g.bytes[0] = {3'b110, cp[10:6]};
      g.bytes[1] = {2'b10, cp[5:0]};
      g.last     = 2'd1;
    end else if (cp <= 21'hffff) begin
      g.bytes[0] = {4'b1110, cp[15:12]};
      g.bytes[1] = {2'b10, cp[11:6]};
      g.bytes[2] = {2'b10, cp[5:0]};
      g.last     = 2'd2;
    end else begin
      g.bytes[0] = {5'b11110, cp[20:18]};
      g.bytes[1] = {2'b10, cp[17:12]};
      g.bytes[2] = {2'b10, cp[11:6]};
      g.bytes[3] = {2'b10, cp[5:0]};
      g.last     = 2'd3;
    end
    return g;
  endfunction

endpackage

// File: sv/jsu_decode.sv
// Next-state and result logic of the JSON string unescaper for one byte.
// Purely combinational; depends on jsu_pkg.
module jsu_decode (
  input  jsu_pkg::dec_state_t st,
  input  logic [7:0]          data_byte,
  input  logic                input_end,
  output jsu_pkg::dec_state_t st_next,
  output jsu_pkg::grp_t       grp
);

  jsu_pkg::hex_t hx;
  logic [15:0]   acc_shift;
  logic [20:0]   pair_cp;

  // Shift in one hex digit and form the supplementary code point of a pair
  assign hx        = jsu_pkg::hex_decode(data_byte);
  assign acc_shift = {st.acc[11:0], hx.val};
  assign pair_cp   = jsu_pkg::SUPP_BASE + {1'b0, st.hi_bits, acc_shift[9:0]};

  // Decode one byte against the current mode
  always_comb begin
    st_next = st;
    grp     = '0;
    unique case (st.mode)
      jsu_pkg::MODE_STR: begin
        if (input_end) begin
          st_next = jsu_pkg::IDLE_STATE;
          grp     = jsu_pkg::error_group(jsu_pkg::ERR_UNTERMINATED);
        end else if (data_byte == jsu_pkg::CH_QUOTE) begin
          st_next.mode = jsu_pkg::MODE_IDLE;
          grp          = jsu_pkg::done_group();
        end else if (data_byte < jsu_pkg::CH_SPACE) begin
          st_next = jsu_pkg::IDLE_STATE;
          grp     = jsu_pkg::error_group(jsu_pkg::ERR_CONTROL_CHAR);
        end else if (data_byte == jsu_pkg::CH_BSLASH) begin
          st_next.mode = jsu_pkg::MODE_ESC;
        end else begin
          grp = jsu_pkg::byte_group(data_byte);
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (input_end) begin
          st_next = jsu_pkg::IDLE_STATE;
          grp     = jsu_pkg::error_group(jsu_pkg::ERR_TRUNC_ESCAPE);
        end else begin
          st_next.mode = jsu_pkg::MODE_STR;
          case (data_byte) inside
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
              grp = jsu_pkg::byte_group(data_byte);
            jsu_pkg::CH_LOW_B: grp = jsu_pkg::byte_group(jsu_pkg::CH_BS);
            jsu_pkg::CH_LOW_F: grp = jsu_pkg::byte_group(jsu_pkg::CH_FF);
            jsu_pkg::CH_LOW_N: grp = jsu_pkg::byte_group(jsu_pkg::CH_LF);
            jsu_pkg::CH_LOW_R: grp = jsu_pkg::byte_group(jsu_pkg::CH_CR);
            jsu_pkg::CH_LOW_T: grp = jsu_pkg::byte_group(jsu_pkg::CH_TAB);
            jsu_pkg::CH_LOW_U: begin
              st_next.mode    = jsu_pkg::MODE_HEXHI;
              st_next.hex_cnt = 2'd0;
              st_next.acc     = 16'd0;
            end
            default: begin
              st_next = jsu_pkg::IDLE_STATE;
              grp     = jsu_pkg::error_group(jsu_pkg::ERR_BAD_ESCAPE);
            end
          endcase
        end
      end
      jsu_pkg::MODE_HEXHI, jsu_pkg::MODE_HEXLO: begin
        if (input_end) begin
          st_next = jsu_pkg::IDLE_STATE;
          grp     = jsu_pkg::error_group(jsu_pkg::ERR_TRUNC_UNICODE);
        end else if (!hx.ok) begin
          st_next = jsu_pkg::IDLE_STATE;
          grp     = jsu_pkg::error_group(jsu_pkg::ERR_BAD_HEX);
        end else if (st.hex_cnt != 2'd3) begin
          st_next.hex_cnt = st.hex_cnt + 2'd1;
          st_next.acc     = acc_shift;
        end else begin
          st_next.hex_cnt = 2'd0;
          st_next.acc     = 16'd0;
          if (st.mode == jsu_pkg::MODE_HEXHI) begin
            if (acc_shift[15:10] == jsu_pkg::SURR_HIGH) begin
              // hold the high half until the low half arrives
              st_next.hi_bits = acc_shift[9:0];
              st_next.mode    = jsu_pkg::MODE_PAIRBS;
            end else if (acc_shift[15:10] == jsu_pkg::SURR_LOW) begin
              st_next = jsu_pkg::IDLE_STATE;
              grp     = jsu_pkg::error_group(jsu_pkg::ERR_STRAY_LOW);
            end else begin
              st_next.mode = jsu_pkg::MODE_STR;
              grp          = jsu_pkg::utf8_group({5'd0, acc_shift});
            end
          end else begin
            if (acc_shift[15:10] != jsu_pkg::SURR_LOW) begin
              st_next = jsu_pkg::IDLE_STATE;
              grp     = jsu_pkg::error_group(jsu_pkg::ERR_BAD_LOW);
            end else begin
              st_next.hi_bits = 10'd0;
              st_next.mode    = jsu_pkg::MODE_STR;
              grp             = jsu_pkg::utf8_group(pair_cp);
            end
          end
        end
      end
      jsu_pkg::MODE_PAIRBS: begin
        if (input_end || data_byte != jsu_pkg::CH_BSLASH) begin
          st_next = jsu_pkg::IDLE_STATE;
          grp     = jsu_pkg::error_group(jsu_pkg::ERR_MISSING_LOW);
        end else begin
          st_next.mode = jsu_pkg::MODE_PAIRU;
        end
      end
      jsu_pkg::MODE_PAIRU: begin
        if (input_end || data_byte != jsu_pkg::CH_LOW_U) begin
          st_next = jsu_pkg::IDLE_STATE;
          grp     = jsu_pkg::error_group(jsu_pkg::ERR_MISSING_LOW);
        end else begin
          st_next.mode    = jsu_pkg::MODE_HEXLO;
          st_next.hex_cnt = 2'd0;
          st_next.acc     = 16'd0;
        end
      end
      default: begin
        // idle and any unused mode: wait for the opening quote
        if (input_end || data_byte != jsu_pkg::CH_QUOTE) begin
          st_next = jsu_pkg::IDLE_STATE;
          grp     = jsu_pkg::error_group(jsu_pkg::ERR_EXPECT_QUOTE);
        end else begin
          st_next      = jsu_pkg::IDLE_STATE;
          st_next.mode = jsu_pkg::MODE_STR;
        end
      end
    endcase
  end

endmodule

// File: sv/json_string_unescape_utf8_unit.sv
// JSON string unescaper to UTF-8: takes one raw byte per transfer, starting
// at the opening quote, and returns the decoded UTF-8 bytes, a done marker on
// the closing quote, or one error result, each run ending with last_of_run.
// Throughput is one input byte per cycle whenever each byte causes at most
// one result and out_stall is low. A byte that completes a \u escape or
// surrogate pair causes up to four results, and the output register delivers
// one result per cycle while out_stall is low, so the next byte that has a
// result of its own waits in the input register until that group drains; a
// byte without a result, such as a hex digit, still passes. An input transfer
// reaches its first result through the input register, then the result
// register. The decoder state advances when a byte leaves the input register.
// No memories. Depends on jsu_pkg and jsu_decode.
module json_string_unescape_utf8_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       input_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       string_done,
  output logic       error_flag,
  output logic [3:0] error_code,
  output logic       last_of_run
);

  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                s1_end;
  jsu_pkg::dec_state_t st;
  jsu_pkg::dec_state_t st_next;
  jsu_pkg::grp_t       grp_new;
  jsu_pkg::grp_t       grp;
  logic                grp_valid;
  logic [1:0]          grp_idx;
  logic                in_xfer;
  logic                out_xfer;
  logic                grp_drain;
  logic                grp_free;
  logic                s1_adv;

  jsu_decode u_decode (
    .st        (st),
    .data_byte (s1_byte),
    .input_end (s1_end),
    .st_next   (st_next),
    .grp       (grp_new)
  );

  // Handshake: advance the input register when its results have room
  assign out_xfer  = grp_valid && !out_stall;
  assign grp_drain = out_xfer && (grp_idx == grp.last);
  assign grp_free  = !grp_valid || grp_drain;
  assign s1_adv    = s1_valid && (!grp_new.has_result || grp_free);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_xfer   = in_valid && !in_stall;

  // Input register and decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      st       <= jsu_pkg::IDLE_STATE;
    end else begin
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte <= data_byte;
      s1_end  <= input_end;
    end
  end

  // Result register: load a group, then step through its bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      grp_idx   <= 2'd0;
    end else if (s1_adv && grp_new.has_result) begin
      grp_valid <= 1'b1;
      grp_idx   <= 2'd0;
    end else if (grp_drain) begin
      grp_valid <= 1'b0;
    end else if (out_xfer) begin
      grp_idx <= grp_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && grp_new.has_result) begin
      grp <= grp_new;
    end
  end

  // Drive result fields from the current group entry
  assign out_valid   = grp_valid;
  assign byte_valid  = (grp.kind == jsu_pkg::KIND_BYTE);
  assign string_done = (grp.kind == jsu_pkg::KIND_DONE);
  assign error_flag  = (grp.kind == jsu_pkg::KIND_ERROR);
  assign out_byte    = byte_valid ? grp.bytes[grp_idx] : 8'd0;
  assign error_code  = grp.err;
  assign last_of_run = (grp_idx == grp.last);

endmodule

// File: sv/jsu_checker.sv
// Port-level assertions for the JSON string unescape unit, bound to the top
// level. Depends on jsu_pkg and json_string_unescape_utf8_unit.
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       string_done,
  input logic       error_flag,
  input logic [3:0] error_code,
  input logic       last_of_run
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("stalled result changed");

  // Each result is exactly one of byte, done or error
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({byte_valid, string_done, error_flag}) == 1)
    else $error("result kind not unique");

  // Done and error end their run
  a_single_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_flag || string_done) |-> last_of_run)
    else $error("done or error not last of run");

  // Only byte runs span more than one result
  a_multi_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> byte_valid)
    else $error("multi-result run carries non-byte");

  // Error code is zero without an error and in range with one
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_flag ? (error_code <= jsu_pkg::ERR_UNTERMINATED)
                              : (error_code == 4'd0)))
    else $error("error code out of range");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .byte_valid  (byte_valid),
  .string_done (string_done),
  .error_flag  (error_flag),
  .error_code  (error_code),
  .last_of_run (last_of_run)
);

// File: verif/json_string_unescape_utf8_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for json_string_unescape_utf8_unit: directed table, then random JSON strings
// in four idling phases, every result checked against an in-file decoder model or a typed row.
// Depends on jsu_pkg and the unit's RTL.
module json_string_unescape_utf8_unit_tb;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int DRAIN_CYCLES    = 16;
  localparam int DIR_ROWS        = 33;

  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_DIGIT9  = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       error_flag;
    logic [3:0] error_code;
    logic       last_of_run;
  } result_t;

  // one input transfer; a checked row carries its result typed in
  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = '0;
  logic       input_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic       error_flag;
  logic [3:0] error_code;
  logic       last_of_run;

  // typed expectation travels with the byte it belongs to
  logic    row_typed = 1'b0;
  result_t row_want = '0;

  int gap_pct = 0;
  int stall_pct = 0;
  int cycle_cnt = 0;
  int fail_count = 0;
  int transfers_in = 0;
  int bytes_out = 0;
  int strings_closed = 0;
  int errors_total = 0;
  int err_seen [10];

  // decoder model state
  jsu_pkg::mode_t dec_mode = jsu_pkg::MODE_IDLE;
  logic [1:0]     digit_cnt = '0;
  logic [15:0]    code_acc = '0;
  logic [9:0]     high_bits = '0;
  result_t        step_res [4];
  result_t        expected_q [$];

  stim_row_t dir_rows [DIR_ROWS];
  stim_row_t text_q [$];

  json_string_unescape_utf8_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .input_end   (input_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .string_done (string_done),
    .error_flag  (error_flag),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- results

  function automatic result_t res_byte(logic [7:0] b);
    result_t r;
    r = '0;
    r.out_byte    = b;
    r.byte_valid  = 1'b1;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic result_t res_err(logic [3:0] code);
    result_t r;
    r = '0;
    r.error_flag  = 1'b1;
    r.error_code  = code;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic result_t res_done();
    result_t r;
    r = '0;
    r.string_done = 1'b1;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------- decoder model

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= CH_DIGIT0 && c <= CH_DIGIT9) return int'(c - CH_DIGIT0);
    if (c >= CH_LOWER_A && c <= jsu_pkg::CH_LOW_F) return int'(c - CH_LOWER_A) + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic int emit_byte(int k, logic [7:0] b);
    step_res[k] = res_byte(b);
    step_res[k].last_of_run = 1'b0;
    return k + 1;
  endfunction

  // drop the string and report one error
  function automatic int abort_string(logic [3:0] code);
    dec_mode  = jsu_pkg::MODE_IDLE;
    digit_cnt = '0;
    code_acc  = '0;
    high_bits = '0;
    step_res[0] = res_err(code);
    return 1;
  endfunction

  function automatic int emit_utf8(logic [20:0] cp);
    int k;
    k = 0;
    if (cp < 21'h80) begin
      k = emit_byte(k, cp[7:0]);
    end else if (cp < 21'h800) begin
      k = emit_byte(k, {3'b110, cp[10:6]});
      k = emit_byte(k, {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      k = emit_byte(k, {4'b1110, cp[15:12]});
      k = emit_byte(k, {2'b10, cp[11:6]});
      k = emit_byte(k, {2'b10, cp[5:0]});
    end else begin
      k = emit_byte(k, {5'b11110, cp[20:18]});
      k = emit_byte(k, {2'b10, cp[17:12]});
      k = emit_byte(k, {2'b10, cp[11:6]});
      k = emit_byte(k, {2'b10, cp[5:0]});
    end
    return k;
  endfunction

  // advance the model by one byte; results land in step_res, count returned
  function automatic int decode_step(logic [7:0] c, logic fin);
    int n;
    int d;
    logic [15:0] code_unit;
    n = 0;
    d = hex_nibble(c);
    case (dec_mode)
      jsu_pkg::MODE_STR: begin
        if (fin) begin
          n = abort_string(jsu_pkg::ERR_UNTERMINATED);
        end else if (c == jsu_pkg::CH_QUOTE) begin
          dec_mode = jsu_pkg::MODE_IDLE;
          step_res[0] = res_done();
          n = 1;
        end else if (c < jsu_pkg::CH_SPACE) begin
          n = abort_string(jsu_pkg::ERR_CONTROL_CHAR);
        end else if (c == jsu_pkg::CH_BSLASH) begin
          dec_mode = jsu_pkg::MODE_ESC;
        end else begin
          n = emit_byte(0, c);
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (fin) begin
          n = abort_string(jsu_pkg::ERR_TRUNC_ESCAPE);
        end else begin
          dec_mode = jsu_pkg::MODE_STR;
          case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: n = emit_byte(0, c);
            jsu_pkg::CH_LOW_B: n = emit_byte(0, jsu_pkg::CH_BS);
            jsu_pkg::CH_LOW_F: n = emit_byte(0, jsu_pkg::CH_FF);
            jsu_pkg::CH_LOW_N: n = emit_byte(0, jsu_pkg::CH_LF);
            jsu_pkg::CH_LOW_R: n = emit_byte(0, jsu_pkg::CH_CR);
            jsu_pkg::CH_LOW_T: n = emit_byte(0, jsu_pkg::CH_TAB);
            jsu_pkg::CH_LOW_U: begin
              dec_mode  = jsu_pkg::MODE_HEXHI;
              digit_cnt = '0;
              code_acc  = '0;
            end
            default: n = abort_string(jsu_pkg::ERR_BAD_ESCAPE);
          endcase
        end
      end
      jsu_pkg::MODE_HEXHI, jsu_pkg::MODE_HEXLO: begin
        if (fin) begin
          n = abort_string(jsu_pkg::ERR_TRUNC_UNICODE);
        end else if (d < 0) begin
          n = abort_string(jsu_pkg::ERR_BAD_HEX);
        end else begin
          code_acc = {code_acc[11:0], d[3:0]};
          if (digit_cnt != 2'd3) begin
            digit_cnt = digit_cnt + 2'd1;
          end else begin
            digit_cnt = '0;
            code_unit = code_acc;
            code_acc  = '0;
            if (dec_mode == jsu_pkg::MODE_HEXHI) begin
              if (code_unit[15:10] == jsu_pkg::SURR_HIGH) begin
                high_bits = code_unit[9:0];
                dec_mode  = jsu_pkg::MODE_PAIRBS;
              end else if (code_unit[15:10] == jsu_pkg::SURR_LOW) begin
                n = abort_string(jsu_pkg::ERR_STRAY_LOW);
              end else begin
                dec_mode = jsu_pkg::MODE_STR;
                n = emit_utf8({5'd0, code_unit});
              end
            end else if (code_unit[15:10] != jsu_pkg::SURR_LOW) begin
              n = abort_string(jsu_pkg::ERR_BAD_LOW);
            end else begin
              n = emit_utf8(jsu_pkg::SUPP_BASE + {1'b0, high_bits, code_unit[9:0]});
              high_bits = '0;
              dec_mode  = jsu_pkg::MODE_STR;
            end
          end
        end
      end
      jsu_pkg::MODE_PAIRBS: begin
        if (fin || c != jsu_pkg::CH_BSLASH) n = abort_string(jsu_pkg::ERR_MISSING_LOW);
        else dec_mode = jsu_pkg::MODE_PAIRU;
      end
      jsu_pkg::MODE_PAIRU: begin
        if (fin || c != jsu_pkg::CH_LOW_U) begin
          n = abort_string(jsu_pkg::ERR_MISSING_LOW);
        end else begin
          dec_mode  = jsu_pkg::MODE_HEXLO;
          digit_cnt = '0;
          code_acc  = '0;
        end
      end
      default: begin
        if (fin || c != jsu_pkg::CH_QUOTE) begin
          n = abort_string(jsu_pkg::ERR_EXPECT_QUOTE);
        end else begin
          dec_mode  = jsu_pkg::MODE_STR;
          digit_cnt = '0;
          code_acc  = '0;
          high_bits = '0;
        end
      end
    endcase
    if (n > 0) step_res[n - 1].last_of_run = 1'b1;
    return n;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic stim_row_t plain(logic [7:0] b);
    stim_row_t r;
    r = '0;
    r.b = b;
    return r;
  endfunction

  function automatic stim_row_t checked(logic [7:0] b, logic fin, result_t want);
    stim_row_t r;
    r.b     = b;
    r.fin   = fin;
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return CH_DIGIT0 + {4'd0, v};
    return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] escape_letter(int i);
    case (i)
      0: return jsu_pkg::CH_QUOTE;
      1: return jsu_pkg::CH_BSLASH;
      2: return jsu_pkg::CH_SLASH;
      3: return jsu_pkg::CH_LOW_B;
      4: return jsu_pkg::CH_LOW_F;
      5: return jsu_pkg::CH_LOW_N;
      6: return jsu_pkg::CH_LOW_R;
      default: return jsu_pkg::CH_LOW_T;
    endcase
  endfunction

  function automatic bit is_escape_letter(logic [7:0] c);
    if (c == jsu_pkg::CH_LOW_U) return 1'b1;
    for (int i = 0; i < 8; i++) if (c == escape_letter(i)) return 1'b1;
    return 1'b0;
  endfunction

  // BMP code point outside the surrogate range, spread over the one- to three-byte UTF-8 lengths
  function automatic logic [15:0] random_bmp();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'h7f));
      1: return 16'($urandom_range(16'h7ff, 16'h80));
      2: return 16'($urandom_range(16'hd7ff, 16'h800));
      default: return 16'($urandom_range(16'hffff, 16'he000));
    endcase
  endfunction

  task automatic queue_byte(logic [7:0] b, logic fin);
    stim_row_t r;
    r = plain(b);
    r.fin = fin;
    text_q.insert(text_q.size(), r);
  endtask

  task automatic queue_hex(logic [15:0] v);
    for (int i = 3; i >= 0; i--) queue_byte(hex_char(v[i * 4 +: 4]), 1'b0);
  endtask

  task automatic queue_escape_u();
    queue_byte(jsu_pkg::CH_BSLASH, 1'b0);
    queue_byte(jsu_pkg::CH_LOW_U, 1'b0);
  endtask

  // one malformed element; the string ends with its error
  task automatic queue_broken();
    logic [7:0] b;
    logic [15:0] code_unit;
    int flavor;
    int digits;
    flavor = $urandom_range(8);
    case (flavor)
      0: queue_byte(8'($urandom_range(31)), 1'b0);
      1: begin
        queue_byte(jsu_pkg::CH_BSLASH, 1'b0);
        queue_byte(8'($urandom_range(255)), 1'b1);
      end
      2: begin
        do b = 8'($urandom_range(255)); while (is_escape_letter(b));
        queue_byte(jsu_pkg::CH_BSLASH, 1'b0);
        queue_byte(b, 1'b0);
      end
      3, 4: begin
        // cut short or spoiled in the high half or, after a high half, in the low one
        if ($urandom_range(1)) begin
          queue_escape_u();
          queue_hex(16'hd800 | 16'($urandom_range(10'h3ff)));
        end
        queue_escape_u();
        digits = $urandom_range(3);
        for (int i = 0; i < digits; i++) queue_byte(hex_char(4'($urandom_range(15))), 1'b0);
        if (flavor == 3) begin
          queue_byte(8'($urandom_range(255)), 1'b1);
        end else begin
          do b = 8'($urandom_range(255)); while (hex_nibble(b) >= 0);
          queue_byte(b, 1'b0);
        end
      end
      5: begin
        queue_escape_u();
        queue_hex(16'hd800 | 16'($urandom_range(10'h3ff)));
        case ($urandom_range(3))
          0: queue_byte(8'($urandom_range(255)), 1'b1);
          1: begin
            do b = 8'($urandom_range(255)); while (b == jsu_pkg::CH_BSLASH);
            queue_byte(b, 1'b0);
          end
          2: begin
            queue_byte(jsu_pkg::CH_BSLASH, 1'b0);
            queue_byte(8'($urandom_range(255)), 1'b1);
          end
          default: begin
            do b = 8'($urandom_range(255)); while (b == jsu_pkg::CH_LOW_U);
            queue_byte(jsu_pkg::CH_BSLASH, 1'b0);
            queue_byte(b, 1'b0);
          end
        endcase
      end
      6: begin
        do code_unit = 16'($urandom_range(16'hffff));
        while (code_unit[15:10] == jsu_pkg::SURR_LOW);
        queue_escape_u();
        queue_hex(16'hd800 | 16'($urandom_range(10'h3ff)));
        queue_escape_u();
        queue_hex(code_unit);
      end
      7: begin
        queue_escape_u();
        queue_hex(16'hdc00 | 16'($urandom_range(10'h3ff)));
      end
      default: queue_byte(8'($urandom_range(255)), 1'b1);
    endcase
  endtask

  // one string token with random content, mostly well formed
  task automatic queue_string();
    logic [7:0] b;
    int segs;
    int pick;
    if ($urandom_range(99) < 8) begin
      // noise while idle
      do b = 8'($urandom_range(255)); while (b == jsu_pkg::CH_QUOTE);
      queue_byte(b, $urandom_range(3) == 0);
      return;
    end
    queue_byte(jsu_pkg::CH_QUOTE, 1'b0);
    segs = $urandom_range(6);
    for (int i = 0; i < segs; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        do b = 8'($urandom_range(255, 32));
        while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
        queue_byte(b, 1'b0);
      end else if (pick < 50) begin
        queue_byte(jsu_pkg::CH_BSLASH, 1'b0);
        queue_byte(escape_letter($urandom_range(7)), 1'b0);
      end else if (pick < 65) begin
        queue_escape_u();
        queue_hex(random_bmp());
      end else if (pick < 80) begin
        queue_escape_u();
        queue_hex(16'hd800 | 16'($urandom_range(10'h3ff)));
        queue_escape_u();
        queue_hex(16'hdc00 | 16'($urandom_range(10'h3ff)));
      end else begin
        queue_broken();
        return;
      end
    end
    if ($urandom_range(9) == 0) queue_byte(8'($urandom_range(255)), 1'b1);
    else queue_byte(jsu_pkg::CH_QUOTE, 1'b0);
  endtask

  // present one transfer, with a random idle gap ahead of it
  task automatic send_row(stim_row_t r);
    logic stalled;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid  <= 1'b1;
    data_byte <= r.b;
    input_end <= r.fin;
    row_typed <= r.typed;
    row_want  <= r.want;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // ---------------------------------------------------------------- monitors

  // predict on every accepted input transfer
  always @(negedge clk) begin : predict_inputs
    int n;
    if (!rst && in_valid && !in_stall) begin
      n = decode_step(data_byte, input_end);
      transfers_in++;
      if (row_typed) expected_q.insert(expected_q.size(), row_want);
      else for (int k = 0; k < n; k++) expected_q.insert(expected_q.size(), step_res[k]);
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // compare every result transfer with the oldest expectation
  always @(negedge clk) begin : check_results
    result_t want;
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {out_byte, byte_valid, string_done, error_flag, error_code, last_of_run};
      if (got.byte_valid) bytes_out++;
      if (got.string_done) strings_closed++;
      if (got.error_flag) begin
        errors_total++;
        if (got.error_code < 4'd10) err_seen[got.error_code]++;
      end
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: out_byte %0d error_code %0d", got.out_byte,
               got.error_code);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("out_byte", int'(want.out_byte), int'(got.out_byte));
        check_field("byte_valid", int'(want.byte_valid), int'(got.byte_valid));
        check_field("string_done", int'(want.string_done), int'(got.string_done));
        check_field("error_flag", int'(want.error_flag), int'(got.error_flag));
        check_field("error_code", int'(want.error_code), int'(got.error_code));
        check_field("last_of_run", int'(want.last_of_run), int'(got.last_of_run));
      end
    end
  end

  // random backpressure on the result side
  always @(posedge clk) begin
    out_stall <= !rst && stall_pct != 0 && $urandom_range(99) < stall_pct;
  end

  // hang guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    string seen_codes;
    foreach (err_seen[i]) err_seen[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    dir_rows = '{
      // idle: any byte but a quote, or end of input, fails at once
      checked(8'h00, 1'b0, res_err(jsu_pkg::ERR_EXPECT_QUOTE)),
      checked(8'hff, 1'b1, res_err(jsu_pkg::ERR_EXPECT_QUOTE)),
      // top byte passes through unchanged; an escaped slash
      plain(jsu_pkg::CH_QUOTE),
      checked(8'hff, 1'b0, res_byte(8'hff)),
      plain(jsu_pkg::CH_BSLASH),
      plain(jsu_pkg::CH_SLASH),
      // escaped NUL
      plain(jsu_pkg::CH_BSLASH), plain(jsu_pkg::CH_LOW_U), plain(CH_DIGIT0), plain(CH_DIGIT0),
      plain(CH_DIGIT0),
      checked(CH_DIGIT0, 1'b0, res_byte(8'h00)),
      // highest pair, mixed-case digits
      plain(jsu_pkg::CH_BSLASH), plain(jsu_pkg::CH_LOW_U),
      plain("d"), plain("B"), plain("f"), plain("F"),
      plain(jsu_pkg::CH_BSLASH), plain(jsu_pkg::CH_LOW_U),
      plain("D"), plain("F"), plain("f"), plain("f"),
      checked(jsu_pkg::CH_QUOTE, 1'b0, res_done()),
      // control char inside the string
      plain(jsu_pkg::CH_QUOTE),
      checked(8'h1f, 1'b0, res_err(jsu_pkg::ERR_CONTROL_CHAR)),
      // bad hex digit before all four have arrived
      plain(jsu_pkg::CH_QUOTE), plain(jsu_pkg::CH_BSLASH), plain(jsu_pkg::CH_LOW_U),
      checked("G", 1'b0, res_err(jsu_pkg::ERR_BAD_HEX)),
      // input ends in plain text
      plain(jsu_pkg::CH_QUOTE),
      checked(8'h00, 1'b1, res_err(jsu_pkg::ERR_UNTERMINATED))
    };
    foreach (dir_rows[i]) send_row(dir_rows[i]);

    // random strings under each idling mix
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 87; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 87; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      while (text_q.size() < ITEMS_PER_PHASE) queue_string();
      while (text_q.size() != 0) send_row(text_q.pop_front());
    end
    in_valid <= 1'b0;

    // drain, then watch for stray results
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    seen_codes = "";
    for (int c = 0; c < 10; c++)
      if (err_seen[c] != 0) seen_codes = {seen_codes, $sformatf(" %0d", c)};
    $display("Fed %0d input transfers; got %0d decoded bytes, %0d closed strings, %0d errors.",
             transfers_in, bytes_out, strings_closed, errors_total);
    $display("Error codes raised:%s", seen_codes);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
